// ===== sv/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg
// Character codes and frame constants for the ASCII setpoint command parser.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam logic [7:0] CHAR_ANGLE = 8'h41;   // 'A'
    localparam logic [7:0] CHAR_SPEED = 8'h53;   // 'S'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CHAR_ONE   = 8'h31;   // '1'
    localparam logic [7:0] CHAR_NINE  = 8'h39;   // '9'
    localparam logic [7:0] CHAR_TERM  = 8'h3B;   // ';'

    localparam logic [2:0] POS_SIGN   = 3'd2;
    localparam logic [2:0] POS_DIGIT1 = 3'd3;
    localparam logic [2:0] POS_DIGIT2 = 3'd4;
    localparam logic [2:0] FRAME_LEN  = 3'd5;

    localparam logic       KIND_ANGLE = 1'b0;
    localparam logic       KIND_SPEED = 1'b1;

endpackage

// ===== sv/ascii_setpoint_command_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_setpoint_command_parser
// Parses five-byte ASCII frames <A|S><0|1><digit><digit>';' into setpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid, byte_stall, rx_byte) carries one received
//   byte per request. Output channel (result_valid, result_stall, target,
//   new_value, angle_now, speed_now) carries one request per valid frame.
//   Bytes that do not complete a valid frame produce no output request.
//   A frame's final byte is captured in the input register when it is
//   accepted and parsed from there; when it completes a valid frame, its
//   result is captured in the result register, which drives result_valid.
//   Throughput: one byte per cycle while byte_stall is low; the input
//   register is parsed against the frame state combinationally.
//   When the receiver stalls, the result register holds its request; the
//   input register keeps draining bytes that produce no result and only
//   stalls the sender when a finishing byte meets a full, stalled result
//   register.
//   Reset clears frame state and both setpoints to zero and empties both
//   registers.
// ----------------------------------------------------------------------------
module ascii_setpoint_command_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        rx_byte,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              target,
    output logic signed [7:0] new_value,
    output logic signed [7:0] angle_now,
    output logic signed [7:0] speed_now
);
    import asp_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // frame state
    logic [2:0] byte_count_reg,    byte_count_next;
    logic       frame_started_reg, frame_started_next;
    logic       frame_kind_reg,    frame_kind_next;
    logic       frame_bad_reg,     frame_bad_next;
    logic       negative_sign_reg, negative_sign_next;
    logic [6:0] partial_value_reg, partial_value_next;
    logic [7:0] angle_setpoint_reg, angle_setpoint_next;
    logic [7:0] speed_setpoint_reg, speed_setpoint_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       target_reg;
    logic [7:0] new_value_reg, angle_now_reg, speed_now_reg;

    logic       accept;
    logic       advance;
    logic       emit;
    logic       is_start;
    logic       is_digit;
    logic [2:0] pos;
    logic [6:0] digit;
    logic [7:0] value;

    assign accept     = byte_valid && !byte_stall;
    assign byte_stall = in_valid_reg && !advance;
    assign advance    = in_valid_reg && (!emit || !out_valid_reg || !result_stall);

    always_comb
    begin
        is_start = (in_byte_reg == CHAR_ANGLE) || (in_byte_reg == CHAR_SPEED);
        is_digit = in_byte_reg inside {[CHAR_ZERO:CHAR_NINE]};
        pos      = byte_count_reg + 3'd1;
        digit    = 7'(in_byte_reg - CHAR_ZERO);

        byte_count_next     = byte_count_reg;
        frame_started_next  = frame_started_reg;
        frame_kind_next     = frame_kind_reg;
        frame_bad_next      = frame_bad_reg;
        negative_sign_next  = negative_sign_reg;
        partial_value_next  = partial_value_reg;
        angle_setpoint_next = angle_setpoint_reg;
        speed_setpoint_next = speed_setpoint_reg;
        emit                = 1'b0;
        value = negative_sign_reg ? 8'(8'd0 - {1'b0, partial_value_reg})
                                  : {1'b0, partial_value_reg};

        if (is_start)
        begin
            // restart the frame on any start byte
            byte_count_next    = 3'd1;
            frame_started_next = 1'b1;
            frame_kind_next    = (in_byte_reg == CHAR_SPEED) ? KIND_SPEED : KIND_ANGLE;
            frame_bad_next     = 1'b0;
            negative_sign_next = 1'b0;
            partial_value_next = 7'd0;
        end
        else if (pos != FRAME_LEN)
        begin
            byte_count_next = pos;
            case (pos)
                POS_SIGN:
                begin
                    if (in_byte_reg == CHAR_ZERO)
                        negative_sign_next = 1'b0;
                    else if (in_byte_reg == CHAR_ONE)
                        negative_sign_next = 1'b1;
                    else
                        frame_bad_next = 1'b1;
                end
                POS_DIGIT1:
                begin
                    if (is_digit)
                        partial_value_next = digit;
                    else
                        frame_bad_next = 1'b1;
                end
                POS_DIGIT2:
                begin
                    if (is_digit)
                        partial_value_next = 7'({partial_value_reg, 3'b000})
                                           + 7'({partial_value_reg, 1'b0}) + digit;
                    else
                        frame_bad_next = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            emit = (in_byte_reg == CHAR_TERM) && frame_started_reg && !frame_bad_reg;
            if (emit)
            begin
                if (frame_kind_reg == KIND_SPEED)
                    speed_setpoint_next = value;
                else
                    angle_setpoint_next = value;
            end
            // drop all frame state at the end of a frame
            byte_count_next    = 3'd0;
            frame_started_next = 1'b0;
            frame_kind_next    = 1'b0;
            frame_bad_next     = 1'b0;
            negative_sign_next = 1'b0;
            partial_value_next = 7'd0;
        end
    end

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && emit)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            byte_count_reg     <= 3'd0;
            frame_started_reg  <= 1'b0;
            frame_kind_reg     <= 1'b0;
            frame_bad_reg      <= 1'b0;
            negative_sign_reg  <= 1'b0;
            partial_value_reg  <= 7'd0;
            angle_setpoint_reg <= 8'd0;
            speed_setpoint_reg <= 8'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                byte_count_reg     <= byte_count_next;
                frame_started_reg  <= frame_started_next;
                frame_kind_reg     <= frame_kind_next;
                frame_bad_reg      <= frame_bad_next;
                negative_sign_reg  <= negative_sign_next;
                partial_value_reg  <= partial_value_next;
                angle_setpoint_reg <= angle_setpoint_next;
                speed_setpoint_reg <= speed_setpoint_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte;
        if (advance && emit)
        begin
            target_reg    <= frame_kind_reg;
            new_value_reg <= value;
            angle_now_reg <= angle_setpoint_next;
            speed_now_reg <= speed_setpoint_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign target       = target_reg;
    assign new_value    = new_value_reg;
    assign angle_now    = angle_now_reg;
    assign speed_now    = speed_now_reg;

endmodule

// ===== bench/ascii_setpoint_command_parser_checker.sv =====
// ----------------------------------------------------------------------------
// ascii_setpoint_command_parser_checker
// Watches both channels of the setpoint parser, predicts each setpoint
// update from the accepted bytes and compares it field by field.
// ----------------------------------------------------------------------------
module ascii_setpoint_command_parser_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              byte_stall,
    input  logic [7:0]        rx_byte,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic              target,
    input  logic signed [7:0] new_value,
    input  logic signed [7:0] angle_now,
    input  logic signed [7:0] speed_now,
    output int                fail_count,
    output int                pending,
    output int                angle_updates,
    output int                speed_updates
);
    timeunit 1ns;
    timeprecision 1ps;
    import asp_pkg::*;

    typedef struct packed {
        logic              target;
        logic signed [7:0] new_value;
        logic signed [7:0] angle_now;
        logic signed [7:0] speed_now;
    } setpoint_update_t;

    setpoint_update_t  setpoint_updates_q [$];

    // predicted parser state
    logic [2:0]        frame_pos;
    logic              frame_open;
    logic              frame_is_speed;
    logic              frame_broken;
    logic              minus;
    logic [6:0]        magnitude;
    logic signed [7:0] angle_sp;
    logic signed [7:0] speed_sp;

    int                fails;
    int                n_angle;
    int                n_speed;

    task clear_frame();
        frame_pos      = 3'd0;
        frame_open     = 1'b0;
        frame_is_speed = KIND_ANGLE;
        frame_broken   = 1'b0;
        minus          = 1'b0;
        magnitude      = 7'd0;
    endtask

    task parse_rx_byte(input logic [7:0] b);
        logic [2:0]        pos;
        logic [7:0]        digit;
        logic              is_digit;
        logic signed [7:0] value;
        setpoint_update_t  upd;

        digit    = b - CHAR_ZERO;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

        // a start byte reopens the frame wherever it falls
        if (b == CHAR_ANGLE || b == CHAR_SPEED)
        begin
            clear_frame();
            frame_open     = 1'b1;
            frame_is_speed = (b == CHAR_SPEED) ? KIND_SPEED : KIND_ANGLE;
            frame_pos      = 3'd1;
            return;
        end

        pos = frame_pos + 3'd1;
        case (pos)
            POS_SIGN:
            begin
                if (b == CHAR_ZERO)
                    minus = 1'b0;
                else if (b == CHAR_ONE)
                    minus = 1'b1;
                else
                    frame_broken = 1'b1;
            end
            POS_DIGIT1:
            begin
                if (is_digit)
                    magnitude = digit[6:0];
                else
                    frame_broken = 1'b1;
            end
            POS_DIGIT2:
            begin
                if (is_digit)
                    magnitude = magnitude * 7'd10 + digit[6:0];
                else
                    frame_broken = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (pos < FRAME_LEN)
        begin
            frame_pos = pos;
            return;
        end

        // fifth byte: judge the frame, drop it unless well formed
        if (b != CHAR_TERM || !frame_open || frame_broken)
        begin
            clear_frame();
            return;
        end

        value = {1'b0, magnitude};
        if (minus)
            value = -value;
        if (frame_is_speed == KIND_SPEED)
            speed_sp = value;
        else
            angle_sp = value;

        upd.target    = frame_is_speed;
        upd.new_value = value;
        upd.angle_now = angle_sp;
        upd.speed_now = speed_sp;
        setpoint_updates_q.push_back(upd);
        clear_frame();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        setpoint_update_t want;

        if (!rst_n)
        begin
            clear_frame();
            angle_sp = 8'sd0;
            speed_sp = 8'sd0;
            setpoint_updates_q.delete();
            fails         = 0;
            n_angle       = 0;
            n_speed       = 0;
            fail_count    <= 0;
            pending       <= 0;
            angle_updates <= 0;
            speed_updates <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (setpoint_updates_q.size() == 0)
                begin
                    if (fails < 10)
                        $display({"%0t: setpoint update with none expected: ",
                                  "target %0d value %0d angle %0d speed %0d"},
                                 $realtime, target, new_value, angle_now, speed_now);
                    fails++;
                end
                else
                begin
                    want = setpoint_updates_q.pop_front();
                    if (want.target !== target || want.new_value !== new_value ||
                        want.angle_now !== angle_now || want.speed_now !== speed_now)
                    begin
                        if (fails < 10)
                            $display({"%0t: mismatch: expected target %0d value %0d ",
                                      "angle %0d speed %0d, got target %0d value %0d ",
                                      "angle %0d speed %0d"},
                                     $realtime, want.target, want.new_value,
                                     want.angle_now, want.speed_now,
                                     target, new_value, angle_now, speed_now);
                        fails++;
                    end
                    if (want.target == KIND_SPEED)
                        n_speed++;
                    else
                        n_angle++;
                end
            end

            if (byte_valid && !byte_stall)
                parse_rx_byte(rx_byte);

            fail_count    <= fails;
            pending       <= setpoint_updates_q.size();
            angle_updates <= n_angle;
            speed_updates <= n_speed;
        end
    end

endmodule

// ===== bench/ascii_setpoint_command_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_setpoint_command_parser_tb
// Drives byte streams into the setpoint parser: a directed set of frames
// for the corner cases, then mostly well-formed random frames mixed with
// broken frames and noise, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module ascii_setpoint_command_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asp_pkg::*;

    localparam int TARGET_BYTES = 1350;
    localparam int CYCLE_LIMIT  = 400000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              byte_valid   = 1'b0;
    logic              byte_stall;
    logic [7:0]        rx_byte      = 8'h00;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              target;
    logic signed [7:0] new_value;
    logic signed [7:0] angle_now;
    logic signed [7:0] speed_now;

    int                fail_count;
    int                pending;
    int                angle_updates;
    int                speed_updates;

    int                cycle_count  = 0;
    int                bytes_sent   = 0;
    int                stall_left   = 0;
    bit                send_quiet   = 1'b0;
    bit                recv_quiet   = 1'b0;

    ascii_setpoint_command_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .target       (target),
        .new_value    (new_value),
        .angle_now    (angle_now),
        .speed_now    (speed_now)
    );

    ascii_setpoint_command_parser_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .rx_byte       (rx_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .target        (target),
        .new_value     (new_value),
        .angle_now     (angle_now),
        .speed_now     (speed_now),
        .fail_count    (fail_count),
        .pending       (pending),
        .angle_updates (angle_updates),
        .speed_updates (speed_updates)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d updates outstanding",
                     cycle_count, pending);
            $display("ascii_setpoint_command_parser_tb: FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap(input bit quiet);
        int r;
        r = int'($urandom_range(0, 99));
        if (quiet || r < 55)
            return 0;
        else if (r < 92)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(6, 25));
    endfunction

    always @(posedge clk)
    begin
        int n;
        if (stall_left > 0)
        begin
            stall_left--;
        end
        else
        begin
            n = pick_gap(recv_quiet);
            result_stall <= (n > 0);
            stall_left = (n > 0) ? n - 1 : 0;
        end
    end

    task send_byte(input logic [7:0] b);
        int idle;
        idle = pick_gap(send_quiet);
        if (idle > 0)
        begin
            byte_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task send_frame(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                    input logic [7:0] b3, input logic [7:0] b4);
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
        send_byte(b3);
        send_byte(b4);
    endtask

    task drain_updates();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // well-formed frame with random content; sometimes spoiled or cut short
    task random_frame();
        logic [7:0] fb [0:4];
        logic [2:0] spoil;
        int         r;
        int         len;

        fb[0] = $urandom_range(0, 1) ? CHAR_SPEED : CHAR_ANGLE;
        fb[1] = $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO;
        fb[2] = CHAR_ZERO + 8'($urandom_range(0, 9));
        fb[3] = CHAR_ZERO + 8'($urandom_range(0, 9));
        fb[4] = CHAR_TERM;
        len   = 5;
        r     = int'($urandom_range(0, 99));
        if (r < 15)
        begin
            spoil     = 3'($urandom_range(1, 4));
            fb[spoil] = 8'($urandom_range(0, 255));
        end
        else if (r < 20)
        begin
            len = int'($urandom_range(1, 4));
        end
        for (int i = 0; i < len; i++)
            send_byte(fb[3'(i)]);
    endtask

    initial
    begin
        int next_pause;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        send_frame(CHAR_ANGLE, CHAR_ZERO, CHAR_NINE, CHAR_NINE, CHAR_TERM);
        send_frame(CHAR_SPEED, CHAR_ONE, CHAR_NINE, CHAR_NINE, CHAR_TERM);
        send_frame(CHAR_ANGLE, CHAR_ONE, CHAR_ZERO, CHAR_ZERO, CHAR_TERM);
        send_frame(8'h00, 8'hFF, CHAR_ZERO, CHAR_NINE, CHAR_TERM);
        send_frame(CHAR_SPEED, 8'h32, CHAR_ZERO, 8'h35, CHAR_TERM);
        send_frame(CHAR_ANGLE, CHAR_ZERO, 8'h3A, 8'h2F, CHAR_TERM);
        send_frame(CHAR_SPEED, CHAR_ZERO, CHAR_ONE, 8'h32, 8'h3A);
        send_byte(CHAR_ANGLE);
        send_byte(CHAR_ZERO);
        send_frame(CHAR_SPEED, CHAR_ONE, 8'h35, CHAR_ZERO, CHAR_TERM);

        // hold off until every update has come out
        drain_updates();

        next_pause = bytes_sent + 300;
        while (bytes_sent < TARGET_BYTES)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                random_frame();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 29) == 0)
            begin
                send_quiet = ($urandom_range(0, 2) == 0);
                recv_quiet = ($urandom_range(0, 2) == 0);
            end
            if (bytes_sent >= next_pause)
            begin
                drain_updates();
                next_pause = bytes_sent + 300;
            end
        end

        drain_updates();
        repeat (8) @(posedge clk);

        $display("sent %0d bytes over %0d cycles; checked %0d angle and %0d speed updates",
                 bytes_sent, cycle_count, angle_updates, speed_updates);
        if (fail_count == 0 && pending == 0)
            $display("ascii_setpoint_command_parser_tb: PASS");
        else
            $display("ascii_setpoint_command_parser_tb: FAIL");
        $finish;
    end

endmodule
